/* rtl/hsm_pkg.sv */
package hsm_pkg;

  typedef enum logic [1:0] {
    KIND_SAFETY   = 2'd0,
    KIND_ACTUATOR = 2'd1,
    KIND_CLEAR    = 2'd2
  } hsm_kind_t;

  typedef enum logic [2:0] {
    CODE_NONE       = 3'd0,
    CODE_OVERTEMP   = 3'd1,
    CODE_DISCONNECT = 3'd2,
    CODE_RUNAWAY    = 3'd3,
    CODE_ACTUATOR   = 3'd4
  } hsm_code_t;

  typedef enum logic [2:0] {
    REG_MIN_TEMP     = 3'd0,
    REG_MAX_TEMP     = 3'd1,
    REG_MAX_RATE     = 3'd2,
    REG_HARD_LIMIT   = 3'd3,
    REG_RUNAWAY_SECS = 3'd4,
    REG_RUNAWAY_RISE = 3'd5
  } hsm_reg_t;

  localparam int CFG_IDX_W = 3;
  localparam int RATE_W    = 16;
  localparam int SECS_W    = 16;
  localparam int RISE_CFG_W = 13;
  localparam int TIME_W    = 32;
  localparam int PCT_W     = 7;

  localparam logic [1:0]        DISCONNECT_LIMIT = 2'd3;
  localparam logic [PCT_W-1:0]  HIGH_POWER_PCT   = 7'd80;
  localparam logic [TIME_W-1:0] CHECKPOINT_MS    = 32'd10000;
  localparam logic [TIME_W-1:0] MS_PER_S         = 32'd1000;
  localparam logic [PCT_W-1:0]  MISMATCH_PCT     = 7'd15;
  localparam logic [PCT_W-1:0]  MIN_CMD_PCT      = 7'd5;

endpackage

/* rtl/hsm_if.sv */
interface hsm_in_if #(parameter int TEMP_WIDTH = 14);
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [31:0]           now_ms;
  logic [TEMP_WIDTH-1:0] temp_sample;
  logic                  temp_valid;
  logic [6:0]            heater_power;
  logic                  heat_enable;
  logic                  probe_present;
  logic [6:0]            commanded_power;
  logic [6:0]            measured_power;
  logic                  overcurrent;

  modport source (output valid, kind, now_ms, temp_sample, temp_valid, heater_power,
                  heat_enable, probe_present, commanded_power, measured_power,
                  overcurrent, input ready);
  modport sink (input valid, kind, now_ms, temp_sample, temp_valid, heater_power,
                heat_enable, probe_present, commanded_power, measured_power,
                overcurrent, output ready);
endinterface

interface hsm_out_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic       fault_latched;
  logic [2:0] fault_code;

  modport source (output valid, ok, fault_latched, fault_code, input ready);
  modport sink (input valid, ok, fault_latched, fault_code, output ready);
endinterface

interface hsm_cfg_if
  import hsm_pkg::*;
#(parameter int DATA_W = 16);
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/hsm_rate_chk.sv */
module hsm_rate_chk
  import hsm_pkg::*;
#(
  parameter int TEMP_WIDTH = 14
) (
  input  logic signed [TEMP_WIDTH-1:0] temp,
  input  logic signed [TEMP_WIDTH-1:0] last_temp,
  input  logic                         last_valid,
  input  logic [TIME_W-1:0]            now_ms,
  input  logic [TIME_W-1:0]            last_time,
  input  logic [RATE_W-1:0]            max_rate,
  output logic                         too_fast
);

  localparam int DIFF_W = TEMP_WIDTH + 1;
  localparam int LHS_W  = DIFF_W + 10;
  localparam int RHS_W  = RATE_W + TIME_W;
  localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        mag;
  logic [TIME_W-1:0]        dt;
  logic [CMP_W-1:0]         lhs;
  logic [CMP_W-1:0]         rhs;

  // |t - last| * 1000 > max_rate * dt, no division needed
  always_comb begin
    diff = DIFF_W'(temp) - DIFF_W'(last_temp);
    mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    dt   = now_ms - last_time;
    lhs  = CMP_W'(mag) * CMP_W'(MS_PER_S);
    rhs  = CMP_W'(max_rate) * CMP_W'(dt);
    too_fast = last_valid && (dt != '0) && (lhs > rhs);
  end

endmodule

/* rtl/heater_safety_monitor_unit.sv */
// Channel  | Dir | Handshake     | Payload
// in_ch    | in  | valid / ready | kind, now_ms, temperature, heater and actuator status
// out_ch   | out | valid / ready | ok, fault_latched, fault_code
// cfg_ch   | in  | valid / ready | index, data (register write, always ready)
//
// Two stages: an input register, then the checks and state update into the result
// register. One item per cycle sustained while the output is ready; an item passes from
// the input register to the result register. The rate multiply (max_rate x elapsed ms)
// sets the critical path. Synchronous active-low reset clears the fault latch, all
// tracking and loads the default thresholds. A stalled output holds the pipe; the input
// register drains into the result register as soon as that frees.
module heater_safety_monitor_unit
  import hsm_pkg::*;
#(
  parameter int TEMP_WIDTH = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  hsm_in_if.sink    in_ch,
  hsm_out_if.source out_ch,
  hsm_cfg_if.sink   cfg_ch
);

  localparam int TW     = TEMP_WIDTH;
  localparam int RISE_W = (TW + 1 > RISE_CFG_W + 1) ? TW + 1 : RISE_CFG_W + 1;

  localparam logic signed [TW-1:0] MIN_TEMP_RST   = TW'(-640);
  localparam logic signed [TW-1:0] MAX_TEMP_RST   = TW'(2400);
  localparam logic signed [TW-1:0] HARD_LIMIT_RST = TW'(1920);

  // configuration
  logic signed [TW-1:0]     min_temp_r, max_temp_r, hard_limit_r;
  logic [RATE_W-1:0]        max_rate_r;
  logic [SECS_W-1:0]        runaway_secs_r;
  logic [RISE_CFG_W-1:0]    runaway_rise_r;

  // input register
  logic                     s1_valid_r;
  hsm_kind_t                s1_kind_r;
  logic [TIME_W-1:0]        s1_now_r;
  logic signed [TW-1:0]     s1_temp_r;
  logic                     s1_tv_r, s1_on_r, s1_conn_r, s1_oc_r;
  logic [PCT_W-1:0]         s1_power_r, s1_cmd_r, s1_meas_r;

  // tracking state
  logic                     faulted_r, faulted_nxt;
  hsm_code_t                code_r, code_nxt;
  logic [1:0]               dcnt_r, dcnt_nxt;
  logic signed [TW-1:0]     lg_temp_r, lg_temp_nxt;
  logic                     lg_valid_r, lg_valid_nxt;
  logic [TIME_W-1:0]        lg_time_r, lg_time_nxt;
  logic                     ra_armed_r, ra_armed_nxt;
  logic [TIME_W-1:0]        ra_start_r, ra_start_nxt;
  logic signed [TW-1:0]     ra_ref_r, ra_ref_nxt;
  logic                     ra_ref_valid_r, ra_ref_valid_nxt;
  logic [TIME_W-1:0]        ra_check_r, ra_check_nxt;

  // result register
  logic                     out_valid_r;
  logic                     out_ok_r, out_ok_nxt;
  logic                     out_latched_r;
  hsm_code_t                out_code_r;

  logic                     fire;
  logic                     too_fast;
  logic                     fail;
  logic [1:0]               dcnt_sat;
  logic signed [RISE_W-1:0] rise;
  logic signed [RISE_W-1:0] min_rise;
  logic [TIME_W-1:0]        secs_ms;
  logic [PCT_W-1:0]         pdiff;

  assign fire         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || fire;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.ok            = out_ok_r;
  assign out_ch.fault_latched = out_latched_r;
  assign out_ch.fault_code    = out_code_r;

  hsm_rate_chk #(.TEMP_WIDTH(TW)) u_rate (
    .temp       (s1_temp_r),
    .last_temp  (lg_temp_r),
    .last_valid (lg_valid_r),
    .now_ms     (s1_now_r),
    .last_time  (lg_time_r),
    .max_rate   (max_rate_r),
    .too_fast   (too_fast)
  );

  always_comb begin
    faulted_nxt      = faulted_r;
    code_nxt         = code_r;
    dcnt_nxt         = dcnt_r;
    lg_temp_nxt      = lg_temp_r;
    lg_valid_nxt     = lg_valid_r;
    lg_time_nxt      = lg_time_r;
    ra_armed_nxt     = ra_armed_r;
    ra_start_nxt     = ra_start_r;
    ra_ref_nxt       = ra_ref_r;
    ra_ref_valid_nxt = ra_ref_valid_r;
    ra_check_nxt     = ra_check_r;
    out_ok_nxt       = 1'b1;
    fail             = 1'b0;
    dcnt_sat         = (dcnt_r == DISCONNECT_LIMIT) ? dcnt_r : dcnt_r + 2'd1;
    rise             = RISE_W'(s1_temp_r) - RISE_W'(ra_ref_r);
    min_rise         = RISE_W'({1'b0, runaway_rise_r});
    secs_ms          = TIME_W'(runaway_secs_r) * MS_PER_S;
    pdiff            = (s1_cmd_r >= s1_meas_r) ? s1_cmd_r - s1_meas_r
                                               : s1_meas_r - s1_cmd_r;

    case (s1_kind_r)
      KIND_SAFETY: begin
        if (faulted_r) begin
          fail = 1'b1;
        end else begin
          if (!s1_conn_r) begin
            dcnt_nxt = dcnt_sat;
            if (dcnt_sat == DISCONNECT_LIMIT) begin
              fail        = 1'b1;
              faulted_nxt = 1'b1;
              code_nxt    = CODE_DISCONNECT;
            end
          end else begin
            dcnt_nxt = 2'd0;
            if (s1_tv_r) begin
              if (s1_temp_r < min_temp_r || s1_temp_r > max_temp_r) begin
                fail        = 1'b1;
                faulted_nxt = 1'b1;
                code_nxt    = CODE_OVERTEMP;
              end else if (too_fast) begin
                fail        = 1'b1;
                faulted_nxt = 1'b1;
                code_nxt    = CODE_ACTUATOR;
              end else begin
                lg_temp_nxt  = s1_temp_r;
                lg_valid_nxt = 1'b1;
                lg_time_nxt  = s1_now_r;
              end
            end
          end

          if (!fail && s1_tv_r && s1_temp_r >= hard_limit_r) begin
            fail        = 1'b1;
            faulted_nxt = 1'b1;
            code_nxt    = CODE_OVERTEMP;
          end

          if (!fail) begin
            if (s1_on_r && s1_power_r > HIGH_POWER_PCT) begin
              if (!ra_armed_r) begin
                ra_armed_nxt     = 1'b1;
                ra_start_nxt     = s1_now_r;
                ra_ref_nxt       = s1_tv_r ? s1_temp_r : '0;
                ra_ref_valid_nxt = s1_tv_r;
                ra_check_nxt     = s1_now_r;
              end else if (s1_now_r - ra_check_r >= CHECKPOINT_MS) begin
                // floor(elapsed / 1000) >= secs  <=>  elapsed >= secs * 1000
                if (s1_tv_r && ra_ref_valid_r && (s1_now_r - ra_start_r >= secs_ms) &&
                    rise < min_rise) begin
                  fail        = 1'b1;
                  faulted_nxt = 1'b1;
                  code_nxt    = CODE_RUNAWAY;
                end else begin
                  ra_ref_nxt       = s1_tv_r ? s1_temp_r : '0;
                  ra_ref_valid_nxt = s1_tv_r;
                  ra_check_nxt     = s1_now_r;
                end
              end
            end else begin
              ra_armed_nxt     = 1'b0;
              ra_start_nxt     = '0;
              ra_ref_nxt       = '0;
              ra_ref_valid_nxt = 1'b0;
              ra_check_nxt     = '0;
            end
          end
        end
        out_ok_nxt = !fail;
      end
      KIND_ACTUATOR: begin
        // a held code is never replaced
        if (s1_oc_r || (pdiff > MISMATCH_PCT && s1_cmd_r > MIN_CMD_PCT)) begin
          out_ok_nxt = 1'b0;
          if (!faulted_r) begin
            faulted_nxt = 1'b1;
            code_nxt    = CODE_ACTUATOR;
          end
        end
      end
      KIND_CLEAR: begin
        faulted_nxt      = 1'b0;
        code_nxt         = CODE_NONE;
        dcnt_nxt         = 2'd0;
        lg_temp_nxt      = '0;
        lg_valid_nxt     = 1'b0;
        lg_time_nxt      = '0;
        ra_armed_nxt     = 1'b0;
        ra_start_nxt     = '0;
        ra_ref_nxt       = '0;
        ra_ref_valid_nxt = 1'b0;
        ra_check_nxt     = '0;
      end
      default: begin
        out_ok_nxt = !faulted_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_temp_r     <= MIN_TEMP_RST;
      max_temp_r     <= MAX_TEMP_RST;
      max_rate_r     <= RATE_W'(160);
      hard_limit_r   <= HARD_LIMIT_RST;
      runaway_secs_r <= SECS_W'(120);
      runaway_rise_r <= RISE_CFG_W'(32);
    end else if (cfg_ch.valid) begin
      case (hsm_reg_t'(cfg_ch.index))
        REG_MIN_TEMP:     min_temp_r     <= cfg_ch.data[TW-1:0];
        REG_MAX_TEMP:     max_temp_r     <= cfg_ch.data[TW-1:0];
        REG_MAX_RATE:     max_rate_r     <= cfg_ch.data[RATE_W-1:0];
        REG_HARD_LIMIT:   hard_limit_r   <= cfg_ch.data[TW-1:0];
        REG_RUNAWAY_SECS: runaway_secs_r <= cfg_ch.data[SECS_W-1:0];
        REG_RUNAWAY_RISE: runaway_rise_r <= cfg_ch.data[RISE_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_kind_r  <= hsm_kind_t'(in_ch.kind);
      s1_now_r   <= in_ch.now_ms;
      s1_temp_r  <= in_ch.temp_sample;
      s1_tv_r    <= in_ch.temp_valid;
      s1_power_r <= in_ch.heater_power;
      s1_on_r    <= in_ch.heat_enable;
      s1_conn_r  <= in_ch.probe_present;
      s1_cmd_r   <= in_ch.commanded_power;
      s1_meas_r  <= in_ch.measured_power;
      s1_oc_r    <= in_ch.overcurrent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      faulted_r      <= 1'b0;
      code_r         <= CODE_NONE;
      dcnt_r         <= 2'd0;
      lg_temp_r      <= '0;
      lg_valid_r     <= 1'b0;
      lg_time_r      <= '0;
      ra_armed_r     <= 1'b0;
      ra_start_r     <= '0;
      ra_ref_r       <= '0;
      ra_ref_valid_r <= 1'b0;
      ra_check_r     <= '0;
    end else if (fire) begin
      faulted_r      <= faulted_nxt;
      code_r         <= code_nxt;
      dcnt_r         <= dcnt_nxt;
      lg_temp_r      <= lg_temp_nxt;
      lg_valid_r     <= lg_valid_nxt;
      lg_time_r      <= lg_time_nxt;
      ra_armed_r     <= ra_armed_nxt;
      ra_start_r     <= ra_start_nxt;
      ra_ref_r       <= ra_ref_nxt;
      ra_ref_valid_r <= ra_ref_valid_nxt;
      ra_check_r     <= ra_check_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_ok_r      <= out_ok_nxt;
      out_latched_r <= faulted_nxt;
      out_code_r    <= code_nxt;
    end
  end

endmodule
